// ----- design/mbrq_pkg.sv -----
// Shared types, constants and codes of the memory budget ring queue.
`timescale 1ns / 1ps

package mbrq_pkg;

    // Sizing and estimate constants.
    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned OVERHEAD_UNITS  = 1;
    localparam int unsigned HEADER_BYTES    = 64;
    localparam int unsigned POINTER_BYTES   = 8;
    localparam int unsigned MB_SHIFT        = 20;
    localparam int unsigned MB_BYTES        = 1024 * 1024;

    // Field widths.
    localparam int unsigned DIM_W       = 16;
    localparam int unsigned BPP_W       = 6;
    localparam int unsigned BYTES_PP_W  = 3;
    localparam int unsigned TAG_W       = 16;
    localparam int unsigned EST_W       = 20;
    localparam int unsigned USAGE_W     = 24;
    localparam int unsigned ENTRY_W     = 5;
    localparam int unsigned CFG_LIMIT_W = 5;
    localparam int unsigned MEM_LIMIT_W = 20;
    localparam int unsigned TOTAL_W     = 36;
    localparam int unsigned MB_W        = TOTAL_W - MB_SHIFT;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned RQ_DEPTH    = 2;

    // Request kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Register indices, taken from paddr[2].
    localparam logic REG_ENTRY_LIMIT = 1'b0;
    localparam logic REG_MEM_LIMIT   = 1'b1;

    // Reset values and limits.
    localparam logic [CFG_LIMIT_W-1:0] ENTRY_LIMIT_RST   = 5'd16;
    localparam logic [MEM_LIMIT_W-1:0] MEM_LIMIT_RST     = 20'd1024;
    localparam logic [EST_W-1:0]       EST_MAX           = '1;
    localparam logic [BYTES_PP_W-1:0]  BYTES_PP_FALLBACK = 3'd3;

    typedef enum logic [2:0] {
        ST_PUSHED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_NO_MEM  = 3'd2,
        ST_POPPED  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } back_state_t;

    // A classified request travelling from the front to the back.
    typedef struct packed {
        logic               kind;
        logic [TAG_W-1:0]   tag;
        logic [EST_W-1:0]   est;
    } req_t;

    // Configuration register contents.
    typedef struct packed {
        logic [CFG_LIMIT_W-1:0] entry_limit;
        logic [MEM_LIMIT_W-1:0] mem_limit_mb;
    } cfg_t;

endpackage

// ----- design/mbrq_if.sv -----
// Request and response channel interfaces of the memory budget ring queue.
`timescale 1ns / 1ps

interface mbrq_in_if;
    import mbrq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [DIM_W-1:0]     image_width;
    logic [DIM_W-1:0]     image_height;
    logic [BPP_W-1:0]     bits_per_pixel;
    logic                 has_row_table;
    logic [TAG_W-1:0]     image_tag;

    modport source (
        output valid, kind, image_width, image_height, bits_per_pixel,
               has_row_table, image_tag,
        input  ready
    );

    modport sink (
        input  valid, kind, image_width, image_height, bits_per_pixel,
               has_row_table, image_tag,
        output ready
    );
endinterface

interface mbrq_out_if;
    import mbrq_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [TAG_W-1:0]     popped_tag;
    logic [EST_W-1:0]     estimate_mb;
    logic [ENTRY_W-1:0]   entry_count;
    logic [USAGE_W-1:0]   usage_mb;

    modport source (
        output valid, status, popped_tag, estimate_mb, entry_count, usage_mb,
        input  ready
    );

    modport sink (
        input  valid, status, popped_tag, estimate_mb, entry_count, usage_mb,
        output ready
    );
endinterface

// ----- design/memory_budget_ring_queue.sv -----
// Top level of the memory budget ring queue with its configuration registers.
`timescale 1ns / 1ps

// A ring queue of image tags admitted against an entry limit and a budget in
// megabytes. A push request is accepted, its footprint is estimated in two
// front stages (width times height, then bytes per pixel, headers and rounding
// to megabytes) and handed through a two-entry request queue to the back part,
// which checks the count and the budget and answers through a result register.
// A pop waits in a read state because the ring storage has a registered read
// port, and the back part takes no new request until that pop is done. The
// back part therefore sets the rate: one push per cycle while each result is
// taken without delay. A finished result sits in an output register,
// and the front keeps accepting up to three more requests while it waits. The
// registers are written through the APB port at byte address 0 (entry limit)
// and 4 (budget).
module memory_budget_ring_queue #(
    parameter int unsigned QUEUE_DEPTH = mbrq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mbrq_in_if.sink                       req,
    mbrq_out_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mbrq_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mbrq_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mbrq_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import mbrq_pkg::*;

    logic [CFG_LIMIT_W-1:0] entry_limit_reg;
    logic [MEM_LIMIT_W-1:0] mem_limit_reg;
    logic                   cfg_write;
    cfg_t                   cfg;
    logic                   q_push;
    req_t                   q_in;
    logic                   q_full;
    logic                   q_valid;
    req_t                   q_head;
    logic                   q_pop;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_limit_reg <= ENTRY_LIMIT_RST;
            mem_limit_reg   <= MEM_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ENTRY_LIMIT: entry_limit_reg <= pwdata[CFG_LIMIT_W-1:0];
                REG_MEM_LIMIT:   mem_limit_reg   <= pwdata[MEM_LIMIT_W-1:0];
                default:         entry_limit_reg <= entry_limit_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[2])
            REG_ENTRY_LIMIT: prdata = APB_DATA_W'(entry_limit_reg);
            REG_MEM_LIMIT:   prdata = APB_DATA_W'(mem_limit_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.entry_limit  = entry_limit_reg;
    assign cfg.mem_limit_mb = mem_limit_reg;

    // Front: request intake and footprint estimate.
    mbrq_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_push (q_push),
        .q_data (q_in),
        .q_full (q_full)
    );

    // Decoupling queue between the front and the back.
    mbrq_req_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .head_data (q_head),
        .pop       (q_pop)
    );

    // Back: admission, ring storage and results.
    mbrq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );
endmodule

// ----- design/mbrq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module mbrq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/mbrq_front.sv -----
// Front part: accepts requests and works out the footprint estimate of a push.
`timescale 1ns / 1ps

module mbrq_front (
    input  logic            clk,
    input  logic            rst_n,
    mbrq_in_if.sink         req,
    output logic            q_push,
    output mbrq_pkg::req_t  q_data,
    input  logic            q_full
);
    import mbrq_pkg::*;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    logic [2*DIM_W-1:0]        area_reg;
    logic [2*DIM_W-1:0]        area_next;
    logic [BYTES_PP_W-1:0]     bytes_pp_reg;
    logic [BYTES_PP_W-1:0]     bytes_pp_next;
    logic [DIM_W-1:0]          height_reg;
    logic                      rows_reg;
    logic                      kind_reg;
    logic [TAG_W-1:0]          tag_reg;

    logic [TOTAL_W-1:0]        scaled;
    logic [TOTAL_W-1:0]        row_bytes;
    logic [TOTAL_W-1:0]        total;
    logic [TOTAL_W-1:0]        rounded;
    logic [EST_W:0]            mb_sum;
    logic [EST_W-1:0]          est;
    logic                      advance;

    // The first stage empties whenever the request queue has room.
    assign advance   = s1_valid_reg && !q_full;
    assign req.ready = !s1_valid_reg || !q_full;

    // Stage one: width times height, and the bytes per pixel.
    always_comb
    begin
        area_next     = {{DIM_W{1'b0}}, req.image_width} * {{DIM_W{1'b0}}, req.image_height};
        bytes_pp_next = req.bits_per_pixel[BPP_W-1:3];
        if (bytes_pp_next == '0)
        begin
            bytes_pp_next = BYTES_PP_FALLBACK;
        end
        s1_valid_next = s1_valid_reg;
        if (req.valid && req.ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            area_reg     <= area_next;
            bytes_pp_reg <= bytes_pp_next;
            height_reg   <= req.image_height;
            rows_reg     <= req.has_row_table;
            kind_reg     <= req.kind;
            tag_reg      <= req.image_tag;
        end
    end

    // Stage two: bytes per pixel by shift and add, then rounding up to megabytes.
    always_comb
    begin
        scaled = '0;
        if (bytes_pp_reg[0])
        begin
            scaled = scaled + TOTAL_W'(area_reg);
        end
        if (bytes_pp_reg[1])
        begin
            scaled = scaled + (TOTAL_W'(area_reg) << 1);
        end
        if (bytes_pp_reg[2])
        begin
            scaled = scaled + (TOTAL_W'(area_reg) << 2);
        end
        row_bytes = TOTAL_W'(height_reg) * TOTAL_W'(POINTER_BYTES)
                    + TOTAL_W'(OVERHEAD_UNITS);
        total = scaled + TOTAL_W'(HEADER_BYTES);
        if (rows_reg)
        begin
            total = total + row_bytes;
        end
        rounded = total + TOTAL_W'(MB_BYTES - 1);
        mb_sum  = (EST_W + 1)'(rounded[TOTAL_W-1:MB_SHIFT]) + (EST_W + 1)'(OVERHEAD_UNITS);
        if (mb_sum == '0)
        begin
            est = EST_W'(1);
        end
        else if (mb_sum > {1'b0, EST_MAX})
        begin
            est = EST_MAX;
        end
        else
        begin
            est = mb_sum[EST_W-1:0];
        end
    end

    assign q_push      = advance;
    assign q_data.kind = kind_reg;
    assign q_data.tag  = tag_reg;
    assign q_data.est  = est;
endmodule

// ----- design/mbrq_req_queue.sv -----
// Short request queue that decouples the front part from the back part.
`timescale 1ns / 1ps

module mbrq_req_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mbrq_pkg::req_t  push_data,
    output logic            full,
    output logic            valid,
    output mbrq_pkg::req_t  head_data,
    input  logic            pop
);
    import mbrq_pkg::*;

    localparam int unsigned PW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
    localparam int unsigned NW = $clog2(RQ_DEPTH + 1);

    req_t          slot_reg [RQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [NW-1:0] count_reg;
    logic [NW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == NW'(RQ_DEPTH));
    assign valid     = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(RQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(RQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- design/mbrq_back.sv -----
// Back part: admission against the count and budget, ring storage and the result register.
`timescale 1ns / 1ps

module mbrq_back #(
    parameter int unsigned QUEUE_DEPTH = mbrq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mbrq_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  mbrq_pkg::req_t  q_data,
    output logic            q_pop,
    mbrq_out_if.source      rsp
);
    import mbrq_pkg::*;

    localparam int unsigned AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned LW     = (CW > CFG_LIMIT_W) ? CW : CFG_LIMIT_W;
    localparam int unsigned SLOT_W = TAG_W + EST_W;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       head_next;
    logic [AW-1:0]       tail_reg;
    logic [AW-1:0]       tail_next;
    logic [CW-1:0]       held_reg;
    logic [CW-1:0]       held_next;
    logic [USAGE_W-1:0]  usage_reg;
    logic [USAGE_W-1:0]  usage_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [TAG_W-1:0]    tag_out_reg;
    logic [TAG_W-1:0]    tag_out_next;
    logic [EST_W-1:0]    est_out_reg;
    logic [EST_W-1:0]    est_out_next;

    logic                ram_we;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_rdata;
    logic [TAG_W-1:0]    rd_tag;
    logic [EST_W-1:0]    rd_est;
    logic [LW-1:0]       limit;
    logic                is_full;
    logic [USAGE_W:0]    usage_sum;
    logic                over_budget;
    logic [USAGE_W-1:0]  rd_est_ext;
    logic                out_free;

    // Ring storage of tag and estimate per entry.
    mbrq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({q_data.tag, q_data.est}),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign rd_tag     = ram_rdata[SLOT_W-1:EST_W];
    assign rd_est     = ram_rdata[EST_W-1:0];
    assign rd_est_ext = USAGE_W'(rd_est);

    // Admission checks; an entry limit above the ring depth acts as the depth.
    always_comb
    begin
        limit = LW'(cfg.entry_limit);
        if (limit > LW'(QUEUE_DEPTH))
        begin
            limit = LW'(QUEUE_DEPTH);
        end
        is_full     = (LW'(held_reg) >= limit);
        usage_sum   = {1'b0, usage_reg} + (USAGE_W + 1)'(q_data.est);
        over_budget = (held_reg != '0)
                      && (usage_sum > (USAGE_W + 1)'(cfg.mem_limit_mb));
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // Sequencer: pushes finish from the idle state, pops wait in the pop state for read data.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        held_next      = held_reg;
        usage_next     = usage_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        tag_out_next   = tag_out_reg;
        est_out_next   = est_out_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_data.kind == KIND_PUSH)
                    begin
                        out_valid_next = 1'b1;
                        tag_out_next   = '0;
                        est_out_next   = q_data.est;
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (over_budget)
                        begin
                            status_next = ST_NO_MEM;
                        end
                        else
                        begin
                            status_next = ST_PUSHED;
                            ram_we      = 1'b1;
                            tail_next   = (tail_reg == AW'(QUEUE_DEPTH - 1)) ?
                                          '0 : tail_reg + 1'b1;
                            held_next   = held_reg + 1'b1;
                            usage_next  = usage_sum[USAGE_W] ? '1 : usage_sum[USAGE_W-1:0];
                        end
                    end
                    else if (held_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                        tag_out_next   = '0;
                        est_out_next   = '0;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = BK_POP;
                    end
                end
            end
            BK_POP:
            begin
                out_valid_next = 1'b1;
                status_next    = ST_POPPED;
                tag_out_next   = rd_tag;
                est_out_next   = rd_est;
                head_next      = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                held_next      = held_reg - 1'b1;
                usage_next     = (usage_reg >= rd_est_ext) ? usage_reg - rd_est_ext : '0;
                state_next     = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            usage_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            held_reg      <= held_next;
            usage_reg     <= usage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        tag_out_reg <= tag_out_next;
        est_out_reg <= est_out_next;
    end

    // The count and usage only move together with a new result, so they are shown directly.
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.popped_tag  = tag_out_reg;
    assign rsp.estimate_mb = est_out_reg;
    assign rsp.entry_count = ENTRY_W'(held_reg);
    assign rsp.usage_mb    = usage_reg;

    // The ring never holds more entries than it has slots.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above ring depth");

    // An empty ring has its read and write positions together.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty ring with diverged pointers");

    // The read-wait cycle of a pop always ends in a popped result.
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_POP) |=> (out_valid_reg && status_reg == ST_POPPED))
        else $error("pop did not produce a result");

    // While a result waits, the accounting it reports must not move.
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(held_reg) && $stable(usage_reg)))
        else $error("accounting changed under a pending result");
endmodule
